FILE: sv/raa_pkg.sv
// raa_pkg: types, sizes and codes for the rectangle atlas allocator
// no dependencies; imported by rect_atlas_allocator_top
package raa_pkg;

    localparam int MAX_FREE = 64;
    localparam int IDX_W    = $clog2(MAX_FREE);
    localparam int CNT_W    = IDX_W + 1;
    localparam int FLD_W    = 15;
    localparam int POS_W    = 14;

    localparam logic [0:0] OP_ALLOC   = 1'b0;
    localparam logic [0:0] OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_RELEASE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [0:0] CFG_BIN_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_BIN_HEIGHT = 1'b1;

    typedef struct packed {
        logic [0:0]       op;
        logic [POS_W-1:0] rect_x;
        logic [POS_W-1:0] rect_y;
        logic [FLD_W-1:0] rect_width;
        logic [FLD_W-1:0] rect_height;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] place_x;
        logic [POS_W-1:0] place_y;
    } out_item_t;

    typedef struct packed {
        logic [FLD_W-1:0] x;
        logic [FLD_W-1:0] y;
        logic [FLD_W-1:0] w;
        logic [FLD_W-1:0] h;
    } entry_t;

endpackage

FILE: sv/rect_atlas_allocator_top.sv
// rect_atlas_allocator_top: guillotine allocator with an unordered free table
// depends on raa_pkg (types, sizes, codes)
//
// channel   | ports                      | payload
// ----------+----------------------------+-------------------------------
// input     | s_valid s_ready s_data     | in_item_t op x y width height
// result    | m_valid m_ready m_data     | out_item_t status place_x/y
// config    | cfg_we cfg_index cfg_data  | bin_width (0), bin_height (1)
//
// one item at a time through a table memory with one read and one write
// port and a small sequencer; an allocate scans every table entry, every
// append and every release runs a merge pass over the entries that
// restarts after each merge
// reset and every bin write rewrite entry zero
// the result register is held until taken; the next item is accepted meanwhile
module rect_atlas_allocator_top
    import raa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [FLD_W-1:0] cfg_data
);

    // sequencer states
    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN_RD = 4'd2;
    localparam logic [3:0] S_SCAN_CK = 4'd3;
    localparam logic [3:0] S_PLACE   = 4'd4;
    localparam logic [3:0] S_DROP_WR = 4'd5;
    localparam logic [3:0] S_APPEND  = 4'd6;
    localparam logic [3:0] S_M_RD    = 4'd7;
    localparam logic [3:0] S_M_CHK   = 4'd8;
    localparam logic [3:0] S_M_MV    = 4'd9;
    localparam logic [3:0] S_M_END   = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    // free table memory
    entry_t           mem [MAX_FREE];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             mem_we;

    logic [3:0]       state_reg, state_next;
    logic [FLD_W-1:0] bin_w_reg, bin_w_next;
    logic [FLD_W-1:0] bin_h_reg, bin_h_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] j_reg, j_next;           // scan / merge walk counter
    logic [IDX_W-1:0] idx_reg, idx_next;       // slot of merge target
    entry_t           a_reg, a_next;           // merge target, held off-memory
    in_item_t         req_reg, req_next;
    logic             best_vld_reg, best_vld_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [FLD_W:0]   best_wt_reg, best_wt_next;
    entry_t           f_reg, f_next;           // chosen free entry
    entry_t           below_reg, below_next;
    entry_t           right_reg, right_next;
    logic             pend_below_reg, pend_below_next;
    logic             pend_right_reg, pend_right_next;
    logic [1:0]       stat_reg, stat_next;
    logic [POS_W-1:0] px_reg, px_next;
    logic [POS_W-1:0] py_reg, py_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    // fit measure of the entry just read
    logic signed [FLD_W+1:0] dw, dh, wt;
    // split of the chosen entry
    entry_t           below_c, right_c;
    logic             has_below, has_right;
    logic [CNT_W:0]   need;
    // adjacency tests, edge sums kept unwrapped
    entry_t           b;
    logic [FLD_W:0]   b_yh, a_yh, b_xw, a_xw;
    logic [FLD_W-1:0] sum_h, sum_w;
    logic             merge_up, merge_down, merge_left, merge_right, merged;
    logic [CNT_W-1:0] last;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_comb begin
        dw = signed'({2'b00, rd_data_reg.w}) - signed'({2'b00, req_reg.rect_width});
        dh = signed'({2'b00, rd_data_reg.h}) - signed'({2'b00, req_reg.rect_height});
        wt = (dw < dh) ? dw : dh;

        right_c   = f_reg;
        below_c   = f_reg;
        right_c.x = f_reg.x + req_reg.rect_width;
        right_c.w = f_reg.w - req_reg.rect_width;
        below_c.y = f_reg.y + req_reg.rect_height;
        below_c.h = f_reg.h - req_reg.rect_height;
        if (f_reg.w < f_reg.h) begin
            right_c.h = req_reg.rect_height;
        end else begin
            below_c.w = req_reg.rect_width;
        end
        has_right = (right_c.w != '0) && (right_c.h != '0);
        has_below = (below_c.w != '0) && (below_c.h != '0);
        need = {1'b0, count_reg} - 1'b1 + {{CNT_W{1'b0}}, has_right}
             + {{CNT_W{1'b0}}, has_below};

        b     = rd_data_reg;
        b_yh  = {1'b0, b.y} + {1'b0, b.h};
        a_yh  = {1'b0, a_reg.y} + {1'b0, a_reg.h};
        b_xw  = {1'b0, b.x} + {1'b0, b.w};
        a_xw  = {1'b0, a_reg.x} + {1'b0, a_reg.w};
        sum_h = a_reg.h + b.h;
        sum_w = a_reg.w + b.w;
        merge_up    = (a_reg.x == b.x) && (a_reg.w == b.w) && ({1'b0, a_reg.y} == b_yh);
        merge_down  = (a_reg.x == b.x) && (a_reg.w == b.w) && !merge_up
                    && ({1'b0, b.y} == a_yh);
        merge_left  = !((a_reg.x == b.x) && (a_reg.w == b.w))
                    && (a_reg.y == b.y) && (a_reg.h == b.h) && ({1'b0, a_reg.x} == b_xw);
        merge_right = !((a_reg.x == b.x) && (a_reg.w == b.w))
                    && (a_reg.y == b.y) && (a_reg.h == b.h) && !merge_left
                    && ({1'b0, b.x} == a_xw);
        merged = merge_up || merge_down || merge_left || merge_right;
        last   = count_reg - 1'b1;
    end

    always_comb begin
        state_next      = state_reg;
        bin_w_next      = bin_w_reg;
        bin_h_next      = bin_h_reg;
        count_next      = count_reg;
        j_next          = j_reg;
        idx_next        = idx_reg;
        a_next          = a_reg;
        req_next        = req_reg;
        best_vld_next   = best_vld_reg;
        best_next       = best_reg;
        best_wt_next    = best_wt_reg;
        f_next          = f_reg;
        below_next      = below_reg;
        right_next      = right_reg;
        pend_below_next = pend_below_reg;
        pend_right_next = pend_right_reg;
        stat_next       = stat_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        raddr           = j_reg[IDX_W-1:0];
        waddr           = idx_reg;
        wdata           = a_reg;
        mem_we          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                // entry zero covers the bin, table empty for a zero size
                waddr      = '0;
                wdata      = '{x: '0, y: '0, w: bin_w_reg, h: bin_h_reg};
                mem_we     = 1'b1;
                count_next = ((bin_w_reg != '0) && (bin_h_reg != '0))
                           ? CNT_W'(1) : '0;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    px_next  = '0;
                    py_next  = '0;
                    j_next   = '0;
                    if (s_data.op == OP_RELEASE) begin
                        stat_next = ST_RELEASE;
                        if ((s_data.rect_width == '0) || (s_data.rect_height == '0)) begin
                            state_next = S_DONE;
                        end else if (count_reg >= CNT_W'(MAX_FREE)) begin
                            stat_next  = ST_FULL;
                            state_next = S_DONE;
                        end else begin
                            a_next = '{x: {1'b0, s_data.rect_x}, y: {1'b0, s_data.rect_y},
                                       w: s_data.rect_width, h: s_data.rect_height};
                            idx_next        = count_reg[IDX_W-1:0];
                            count_next      = count_reg + 1'b1;
                            pend_below_next = 1'b0;
                            pend_right_next = 1'b0;
                            state_next      = S_M_RD;
                        end
                    end else if ((s_data.rect_width > bin_w_reg)
                              || (s_data.rect_height > bin_h_reg)) begin
                        stat_next  = ST_NO_FIT;
                        state_next = S_DONE;
                    end else begin
                        best_vld_next = 1'b0;
                        state_next    = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (j_reg >= count_reg) begin
                    state_next = S_PLACE;
                end else begin
                    state_next = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                // first entry with the smallest non-negative short-side leftover
                if (wt >= 0 && (!best_vld_reg || wt[FLD_W:0] < best_wt_reg)) begin
                    best_vld_next = 1'b1;
                    best_next     = j_reg[IDX_W-1:0];
                    best_wt_next  = wt[FLD_W:0];
                    f_next        = rd_data_reg;
                end
                j_next     = j_reg + 1'b1;
                state_next = S_SCAN_RD;
            end
            S_PLACE: begin
                if (!best_vld_reg) begin
                    stat_next  = ST_NO_FIT;
                    state_next = S_DONE;
                end else if (need > (CNT_W+1)'(MAX_FREE)) begin
                    stat_next  = ST_FULL;
                    state_next = S_DONE;
                end else begin
                    stat_next       = ST_PLACED;
                    px_next         = f_reg.x[POS_W-1:0];
                    py_next         = f_reg.y[POS_W-1:0];
                    below_next      = below_c;
                    right_next      = right_c;
                    pend_below_next = has_below;
                    pend_right_next = has_right;
                    count_next      = last;
                    // last entry moves into the chosen slot
                    raddr           = last[IDX_W-1:0];
                    if ({1'b0, best_reg} == last) begin
                        state_next = S_APPEND;
                    end else begin
                        state_next = S_DROP_WR;
                    end
                end
            end
            S_DROP_WR: begin
                waddr      = best_reg;
                wdata      = rd_data_reg;
                mem_we     = 1'b1;
                state_next = S_APPEND;
            end
            S_APPEND: begin
                j_next   = '0;
                idx_next = count_reg[IDX_W-1:0];
                if (pend_below_reg) begin
                    a_next          = below_reg;
                    pend_below_next = 1'b0;
                    count_next      = count_reg + 1'b1;
                    state_next      = S_M_RD;
                end else if (pend_right_reg) begin
                    a_next          = right_reg;
                    pend_right_next = 1'b0;
                    count_next      = count_reg + 1'b1;
                    state_next      = S_M_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_M_RD: begin
                if (j_reg >= count_reg) begin
                    state_next = S_M_END;
                end else if (j_reg[IDX_W-1:0] == idx_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    state_next = S_M_CHK;
                end
            end
            S_M_CHK: begin
                if (merged) begin
                    if (merge_up) begin
                        a_next.y = b.y;
                        a_next.h = sum_h;
                    end else if (merge_down) begin
                        a_next.h = sum_h;
                    end else if (merge_left) begin
                        a_next.x = b.x;
                        a_next.w = sum_w;
                    end else begin
                        a_next.w = sum_w;
                    end
                    // drop entry j: last entry takes its slot
                    if ({1'b0, idx_reg} == last) begin
                        idx_next   = j_reg[IDX_W-1:0];
                        count_next = last;
                        j_next     = '0;
                        state_next = S_M_RD;
                    end else begin
                        raddr      = last[IDX_W-1:0];
                        state_next = S_M_MV;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_M_RD;
                end
            end
            S_M_MV: begin
                waddr      = j_reg[IDX_W-1:0];
                wdata      = rd_data_reg;
                mem_we     = 1'b1;
                count_next = last;
                j_next     = '0;
                state_next = S_M_RD;
            end
            S_M_END: begin
                mem_we     = 1'b1;
                state_next = S_APPEND;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: stat_reg, place_x: px_reg, place_y: py_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase

        // bin writes only arrive while idle, which the block does not enforce; table restarts from the new bin
        if (cfg_we) begin
            if (cfg_index == CFG_BIN_WIDTH) begin
                bin_w_next = cfg_data;
            end else begin
                bin_h_next = cfg_data;
            end
            state_next = S_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            bin_w_reg   <= FLD_W'(1024);
            bin_h_reg   <= FLD_W'(1024);
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bin_w_reg   <= bin_w_next;
            bin_h_reg   <= bin_h_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        j_reg          <= j_next;
        idx_reg        <= idx_next;
        a_reg          <= a_next;
        req_reg        <= req_next;
        best_vld_reg   <= best_vld_next;
        best_reg       <= best_next;
        best_wt_reg    <= best_wt_next;
        f_reg          <= f_next;
        below_reg      <= below_next;
        right_reg      <= right_next;
        pend_below_reg <= pend_below_next;
        pend_right_reg <= pend_right_next;
        stat_reg       <= stat_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
